>>> rtl/lkr_pkg.sv
// Shared types and constants for the link keepalive/retry block.
// No dependencies; imported by lkr_timer, lkr_core and the top level.
`timescale 1ns / 1ps

package lkr_pkg;

	// Request codes on the input side
	localparam logic [1:0] REQ_TICK       = 2'd0;
	localparam logic [1:0] REQ_CONNECT    = 2'd1;
	localparam logic [1:0] REQ_DISCONNECT = 2'd2;
	localparam logic [1:0] REQ_MESSAGE    = 2'd3;

	// Received message kinds
	localparam logic [2:0] MSG_UNDEF    = 3'd0;
	localparam logic [2:0] MSG_GREETING = 3'd1;
	localparam logic [2:0] MSG_PING     = 3'd2;
	localparam logic [2:0] MSG_PONG     = 3'd3;
	localparam logic [2:0] MSG_DATA     = 3'd4;

	// Outgoing message kinds
	localparam logic [1:0] SEND_NONE     = 2'd0;
	localparam logic [1:0] SEND_GREETING = 2'd1;
	localparam logic [1:0] SEND_PING     = 2'd2;
	localparam logic [1:0] SEND_PONG     = 2'd3;

	// Reported link state codes
	localparam logic [1:0] LINK_DISCONNECTED = 2'd0;
	localparam logic [1:0] LINK_WAITING      = 2'd1;
	localparam logic [1:0] LINK_READY        = 2'd2;
	localparam logic [1:0] LINK_FAILED       = 2'd3;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_TIMEOUT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEEPALIVE_INTERVAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DISCONNECT_TIMEOUT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID             = 3'd4;

	localparam int unsigned LIMIT_W = 16;
	localparam int unsigned RETRY_W = 8;
	localparam int unsigned ID_W    = 32;

	// Link state machine, one-hot
	typedef enum logic [3:0] {
		MODE_DISC  = 4'b0001,
		MODE_WAIT  = 4'b0010,
		MODE_READY = 4'b0100,
		MODE_FAIL  = 4'b1000
	} mode_t;

	// Per-timer operation for one step
	typedef enum logic [1:0] {
		TMR_HOLD    = 2'd0,
		TMR_ADVANCE = 2'd1,
		TMR_RESTART = 2'd2,
		TMR_STOP    = 2'd3
	} tmr_op_t;

	typedef struct packed {
		tmr_op_t conn;
		tmr_op_t keep;
		tmr_op_t sil;
	} tmr_ctrl_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] connect_timeout;
		logic [LIMIT_W-1:0] keepalive_interval;
		logic [LIMIT_W-1:0] disconnect_timeout;
		logic [RETRY_W-1:0] max_retries;
		logic [ID_W-1:0]    own_id;
	} cfg_t;

	function automatic logic [1:0] mode_code(input mode_t m);
		logic [1:0] code;
		code = LINK_DISCONNECTED;
		unique case (m)
			MODE_DISC:  code = LINK_DISCONNECTED;
			MODE_WAIT:  code = LINK_WAITING;
			MODE_READY: code = LINK_READY;
			MODE_FAIL:  code = LINK_FAILED;
			default:    code = LINK_DISCONNECTED;
		endcase
		return code;
	endfunction

endpackage

>>> rtl/link_keepalive_retry_fsm_top.sv
// Top level of the link keepalive/retry block: stream ports, config registers,
// input and result registers. Depends on lkr_pkg and lkr_core.
`timescale 1ns / 1ps

// Link keepalive and retry controller. Each input transaction is one event
// (tick, connect request, disconnect request or decoded received message) and
// yields exactly one result transaction: the message to send, the pong id,
// and the link state and retry count after the event. The block takes one
// transaction per clock cycle while the result stream is not stalled; each
// event passes the input register and then the result register, with the
// next-state logic of the link state machine between the two. Configuration
// registers are written through the cfg port, which is always ready; write
// them only while no transaction is in flight. Indexes past the last
// register are ignored. Timers are TIMER_BITS wide and saturate.

module link_keepalive_retry_fsm_top
	import lkr_pkg::*;
#(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [39:0]          s_tdata,  // [31:0] peer_id, [32] send_ok, [39:33] zero
	input  logic [4:0]           s_tuser,  // [1:0] req_type, [4:2] msg_kind
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [47:0]          m_tdata,  // [31:0] pong_value, [33:32] link_state,
	                                       // [41:34] retries_used, [47:42] zero
	output logic [1:0]           m_tuser   // [1:0] send_kind
);

	cfg_t cfg_q;

	// input register
	logic              vld_s1;
	logic [1:0]        req_s1;
	logic [2:0]        kind_s1;
	logic [ID_W-1:0]   peer_s1;
	logic              ok_s1;

	// result register
	logic              vld_s2;
	logic [1:0]        send_s2;
	logic [ID_W-1:0]   pong_s2;
	logic [1:0]        state_s2;
	logic [RETRY_W-1:0] retry_s2;

	logic              step;
	logic [1:0]        send_kind;
	logic [ID_W-1:0]   pong_value;
	logic [1:0]        link_state;
	logic [RETRY_W-1:0] retries_used;

	// Advance the staged event whenever the result register is free or drains
	assign step      = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready  = !vld_s1 || step;
	assign cfg_ready = 1'b1;

	// Configuration registers; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.connect_timeout    <= LIMIT_W'(1000);
			cfg_q.keepalive_interval <= LIMIT_W'(250);
			cfg_q.disconnect_timeout <= LIMIT_W'(2000);
			cfg_q.max_retries        <= RETRY_W'(3);
			cfg_q.own_id             <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CONNECT_TIMEOUT:    cfg_q.connect_timeout    <= cfg_data[LIMIT_W-1:0];
				CFG_KEEPALIVE_INTERVAL: cfg_q.keepalive_interval <= cfg_data[LIMIT_W-1:0];
				CFG_DISCONNECT_TIMEOUT: cfg_q.disconnect_timeout <= cfg_data[LIMIT_W-1:0];
				CFG_MAX_RETRIES:        cfg_q.max_retries        <= cfg_data[RETRY_W-1:0];
				CFG_OWN_ID:             cfg_q.own_id             <= cfg_data[ID_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register: hold the event until the core consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			vld_s1 <= 1'b1;
		end else if (step) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1  <= s_tuser[1:0];
			kind_s1 <= s_tuser[4:2];
			peer_s1 <= s_tdata[31:0];
			ok_s1   <= s_tdata[32];
		end
	end

	lkr_core #(.TIMER_BITS(TIMER_BITS)) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (step),
		.cfg          (cfg_q),
		.req_type     (req_s1),
		.msg_kind     (kind_s1),
		.peer_id      (peer_s1),
		.send_ok      (ok_s1),
		.send_kind    (send_kind),
		.pong_value   (pong_value),
		.link_state   (link_state),
		.retries_used (retries_used)
	);

	// Result register: load on step, release when the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (step) begin
			vld_s2 <= 1'b1;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			send_s2  <= send_kind;
			pong_s2  <= pong_value;
			state_s2 <= link_state;
			retry_s2 <= retries_used;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {6'b0, retry_s2, state_s2, pong_s2};
	assign m_tuser  = send_s2;

endmodule

>>> rtl/lkr_timer.sv
// Saturating tick timer with run flag for the link keepalive/retry block.
// Depends on lkr_pkg (tmr_op_t).
`timescale 1ns / 1ps

module lkr_timer
	import lkr_pkg::*;
#(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  tmr_op_t               op,
	output logic [TIMER_BITS-1:0] adv_ticks
);

	logic [TIMER_BITS-1:0] ticks_q;
	logic                  run_q;

	// Value after one tick; saturate at all ones
	assign adv_ticks = (run_q && (ticks_q != {TIMER_BITS{1'b1}}))
		? ticks_q + TIMER_BITS'(1) : ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= '0;
			run_q   <= 1'b0;
		end else if (en) begin
			case (op)
				TMR_ADVANCE: ticks_q <= adv_ticks;
				TMR_RESTART: begin
					ticks_q <= '0;
					run_q   <= 1'b1;
				end
				TMR_STOP: begin
					ticks_q <= '0;
					run_q   <= 1'b0;
				end
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/lkr_core.sv
// Link state machine, retry count and learned id with the three timers.
// Depends on lkr_pkg and lkr_timer; result is combinational, state commits on en.
`timescale 1ns / 1ps

module lkr_core
	import lkr_pkg::*;
#(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  cfg_t               cfg,
	input  logic [1:0]         req_type,
	input  logic [2:0]         msg_kind,
	input  logic [ID_W-1:0]    peer_id,
	input  logic               send_ok,
	output logic [1:0]         send_kind,
	output logic [ID_W-1:0]    pong_value,
	output logic [1:0]         link_state,
	output logic [RETRY_W-1:0] retries_used
);

	localparam int unsigned CMP_W = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;

	mode_t               mode_q, mode_d;
	logic [RETRY_W-1:0]  retry_q, retry_d;
	logic [ID_W-1:0]     learned_q;
	tmr_ctrl_t           tctl;
	logic [TIMER_BITS-1:0] conn_adv, keep_adv, sil_adv;
	logic [CMP_W-1:0]    watch, limit;
	logic                expired, keep_due;

	lkr_timer #(.TIMER_BITS(TIMER_BITS)) u_conn (
		.clk(clk), .arst_n(arst_n), .en(en), .op(tctl.conn), .adv_ticks(conn_adv)
	);
	lkr_timer #(.TIMER_BITS(TIMER_BITS)) u_keep (
		.clk(clk), .arst_n(arst_n), .en(en), .op(tctl.keep), .adv_ticks(keep_adv)
	);
	lkr_timer #(.TIMER_BITS(TIMER_BITS)) u_sil (
		.clk(clk), .arst_n(arst_n), .en(en), .op(tctl.sil), .adv_ticks(sil_adv)
	);

	assign watch = (mode_q == MODE_WAIT) ? CMP_W'(conn_adv) : CMP_W'(sil_adv);
	assign limit = (mode_q == MODE_WAIT) ? CMP_W'(cfg.connect_timeout)
		: CMP_W'(cfg.disconnect_timeout);
	assign expired  = watch > limit;
	assign keep_due = CMP_W'(keep_adv) > CMP_W'(cfg.keepalive_interval);

	always_comb begin
		mode_d     = mode_q;
		retry_d    = retry_q;
		tctl       = '{conn: TMR_HOLD, keep: TMR_HOLD, sil: TMR_HOLD};
		send_kind  = SEND_NONE;
		pong_value = '0;
		unique case (req_type)
			REQ_TICK: begin
				tctl = '{conn: TMR_ADVANCE, keep: TMR_ADVANCE, sil: TMR_ADVANCE};
				if ((mode_q == MODE_WAIT) || (mode_q == MODE_READY)) begin
					if (expired) begin
						if (retry_q < cfg.max_retries) begin
							// retry: count it and reconnect; a refused greeting fails the link
							retry_d   = retry_q + RETRY_W'(1);
							send_kind = SEND_GREETING;
							if (send_ok) begin
								mode_d = MODE_WAIT;
								tctl = '{conn: TMR_RESTART, keep: TMR_RESTART,
									sil: TMR_STOP};
							end else begin
								mode_d  = MODE_FAIL;
								retry_d = '0;
								tctl = '{conn: TMR_STOP, keep: TMR_STOP, sil: TMR_STOP};
							end
						end else begin
							// give up
							retry_d = '0;
							tctl = '{conn: TMR_STOP, keep: TMR_STOP, sil: TMR_STOP};
							mode_d = (mode_q == MODE_WAIT) ? MODE_FAIL : MODE_DISC;
						end
					end else if (keep_due) begin
						send_kind = (mode_q == MODE_WAIT) ? SEND_GREETING : SEND_PING;
						tctl.keep = TMR_RESTART;
					end
				end
			end
			REQ_CONNECT: begin
				send_kind = SEND_GREETING;
				if (send_ok) begin
					mode_d = MODE_WAIT;
					tctl = '{conn: TMR_RESTART, keep: TMR_RESTART, sil: TMR_STOP};
				end else begin
					mode_d  = MODE_FAIL;
					retry_d = '0;
					tctl = '{conn: TMR_STOP, keep: TMR_STOP, sil: TMR_STOP};
				end
			end
			REQ_DISCONNECT: begin
				mode_d  = MODE_DISC;
				retry_d = '0;
				tctl = '{conn: TMR_STOP, keep: TMR_STOP, sil: TMR_STOP};
			end
			REQ_MESSAGE: begin
				tctl.sil = TMR_RESTART;
				retry_d  = '0;
				case (msg_kind)
					MSG_GREETING: begin
						if (mode_q == MODE_WAIT)
							mode_d = MODE_READY;
						else if (mode_q == MODE_READY)
							send_kind = SEND_GREETING;
					end
					MSG_PING: begin
						if (mode_q == MODE_READY) begin
							send_kind  = SEND_PONG;
							pong_value = (cfg.own_id != '0) ? cfg.own_id : learned_q;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		link_state   = mode_code(mode_d);
		retries_used = retry_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_DISC;
			retry_q   <= '0;
			learned_q <= '0;
		end else if (en) begin
			mode_q  <= mode_d;
			retry_q <= retry_d;
			if ((req_type == REQ_MESSAGE) && (msg_kind == MSG_PONG))
				learned_q <= peer_id;
		end
	end

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for link_keepalive_retry_fsm_top: directed and random event streams,
// an event-level model of the link state machine, and a scoreboard on the result stream.
// Depends on lkr_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_top;
	import lkr_pkg::*;

	// Timers in the block are 16 bits wide at the default parameter value
	localparam logic [15:0] TMR_MAX         = 16'hFFFF;
	localparam int unsigned WATCHDOG_CYCLES = 5000;
	localparam int unsigned LONG_HOLD       = 300;
	localparam int unsigned MAX_REPORTS     = 10;
	// Kind code past the last defined one; the block must treat it like data
	localparam logic [2:0]  MSG_RESERVED_HI = 3'd7;

	typedef struct packed {
		logic [1:0]  send_kind;
		logic [31:0] pong_value;
		logic [1:0]  link_state;
		logic [7:0]  retries_used;
	} link_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [4:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;

	always #2 clk = ~clk;

	link_keepalive_retry_fsm_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// Model copy of the block state and its registers
	logic [1:0]  lk_mode;
	logic [15:0] conn_ticks, keep_ticks, sil_ticks;
	logic        conn_run, keep_run, sil_run;
	logic [7:0]  retry_cnt;
	logic [31:0] learned_peer;
	logic [15:0] lim_connect, lim_keepalive, lim_silence;
	logic [7:0]  retry_limit;
	logic [31:0] local_id;

	link_result_t expected_results[$];

	// Knobs for the input driver and the receiver process
	bit          tx_gaps = 1'b1;
	bit          rx_gaps = 1'b1;
	int unsigned rx_hold_req = 0;

	int unsigned n_items, n_results, n_cfg, n_retries, n_giveups, n_errors;
	int unsigned n_sends[4];

	// ------------------------------------------------------------------
	// Link model
	// ------------------------------------------------------------------
	function automatic logic [15:0] tick_up(input logic [15:0] t, input logic run);
		// hold at all ones once there
		return (run && t != TMR_MAX) ? t + 16'd1 : t;
	endfunction

	task automatic link_clear();
		retry_cnt  = '0;
		conn_ticks = '0;
		conn_run   = 1'b0;
		keep_ticks = '0;
		keep_run   = 1'b0;
		sil_ticks  = '0;
		sil_run    = 1'b0;
	endtask

	task automatic link_connect(input logic ok);
		lk_mode    = LINK_WAITING;
		conn_ticks = '0;
		conn_run   = 1'b1;
		keep_ticks = '0;
		keep_run   = 1'b1;
		sil_ticks  = '0;
		sil_run    = 1'b0;
		// a greeting the transport refuses drops the link to failed
		if (!ok) begin
			link_clear();
			lk_mode = LINK_FAILED;
		end
	endtask

	task automatic link_predict(input logic [1:0] req, input logic [2:0] kind,
			input logic [31:0] peer, input logic ok, output link_result_t res);
		logic [1:0]  snd;
		logic [31:0] pong;
		logic [15:0] watch;
		logic [15:0] lim;
		snd  = SEND_NONE;
		pong = '0;
		case (req)
			REQ_TICK: begin
				conn_ticks = tick_up(conn_ticks, conn_run);
				keep_ticks = tick_up(keep_ticks, keep_run);
				sil_ticks  = tick_up(sil_ticks, sil_run);
				if (lk_mode == LINK_WAITING || lk_mode == LINK_READY) begin
					watch = (lk_mode == LINK_WAITING) ? conn_ticks : sil_ticks;
					lim   = (lk_mode == LINK_WAITING) ? lim_connect : lim_silence;
					if (watch > lim) begin
						if (retry_cnt < retry_limit) begin
							retry_cnt = retry_cnt + 8'd1;
							n_retries++;
							link_connect(ok);
							snd = SEND_GREETING;
						end else begin
							n_giveups++;
							lk_mode = (lk_mode == LINK_WAITING) ? LINK_FAILED
							                                    : LINK_DISCONNECTED;
							link_clear();
						end
					end else if (keep_ticks > lim_keepalive) begin
						snd        = (lk_mode == LINK_WAITING) ? SEND_GREETING : SEND_PING;
						keep_ticks = '0;
						keep_run   = 1'b1;
					end
				end
			end
			REQ_CONNECT: begin
				link_connect(ok);
				snd = SEND_GREETING;
			end
			REQ_DISCONNECT: begin
				link_clear();
				lk_mode = LINK_DISCONNECTED;
			end
			default: begin
				// any received message counts as contact
				sil_ticks = '0;
				sil_run   = 1'b1;
				retry_cnt = '0;
				case (kind)
					MSG_GREETING: begin
						if (lk_mode == LINK_WAITING)
							lk_mode = LINK_READY;
						else if (lk_mode == LINK_READY)
							snd = SEND_GREETING;
					end
					MSG_PING: begin
						if (lk_mode == LINK_READY) begin
							snd  = SEND_PONG;
							pong = (local_id != '0) ? local_id : learned_peer;
						end
					end
					MSG_PONG: learned_peer = peer;
					default: ;
				endcase
			end
		endcase
		res = '{snd, pong, lk_mode, retry_cnt};
	endtask

	// ------------------------------------------------------------------
	// Drivers: all inputs change at the falling edge
	// ------------------------------------------------------------------
	task automatic send_event(input logic [1:0] req, input logic [2:0] kind,
			input logic [31:0] peer, input logic ok);
		link_result_t res;
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= {kind, req};
		s_tdata  <= {7'd0, ok, peer};
		do @(posedge clk); while (!s_tready);
		link_predict(req, kind, peer, ok, res);
		expected_results.push_back(res);
		n_items++;
		n_sends[res.send_kind]++;
		@(negedge clk);
	endtask

	// Drop the input valid and wait until every result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		wait (expected_results.size() == 0);
		repeat (4) @(negedge clk);
	endtask

	// Leaves cfg_valid high so back-to-back writes follow without a gap
	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_CONNECT_TIMEOUT:    lim_connect   = data[15:0];
			CFG_KEEPALIVE_INTERVAL: lim_keepalive = data[15:0];
			CFG_DISCONNECT_TIMEOUT: lim_silence   = data[15:0];
			CFG_MAX_RETRIES:        retry_limit   = data[7:0];
			CFG_OWN_ID:             local_id      = data;
			default: ;
		endcase
		n_cfg++;
		@(negedge clk);
	endtask

	// Write all five registers; junk in the unused upper bits must be dropped
	task automatic apply_config(input logic [15:0] ct, input logic [15:0] ki,
			input logic [15:0] dt, input logic [7:0] mr, input logic [31:0] oid);
		cfg_write(CFG_CONNECT_TIMEOUT,    {16'($urandom), ct});
		cfg_write(CFG_KEEPALIVE_INTERVAL, {16'($urandom), ki});
		cfg_write(CFG_DISCONNECT_TIMEOUT, {16'($urandom), dt});
		cfg_write(CFG_MAX_RETRIES,        {24'($urandom), mr});
		cfg_write(CFG_OWN_ID,             oid);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Receiver: random stall bursts, plus one long hold on request
	initial begin : rx_ready_drive
		int unsigned stall_left;
		int unsigned hold_left;
		stall_left = 0;
		hold_left  = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_req != 0) begin
				hold_left   = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (rx_gaps && $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(1, 8) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Scoreboard: compare each result transaction with the oldest prediction
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input link_result_t want,
			input link_result_t got);
		n_errors++;
		if (n_errors <= MAX_REPORTS) begin
			$display("%0t: %s: expected kind=%0d pong=%h state=%0d retries=%0d",
			         $realtime, what, want.send_kind, want.pong_value, want.link_state,
			         want.retries_used);
			$display("%0t: %s: actual   kind=%0d pong=%h state=%0d retries=%0d",
			         $realtime, what, got.send_kind, got.pong_value, got.link_state,
			         got.retries_used);
		end
	endtask

	always @(posedge clk) begin : result_check
		link_result_t got;
		link_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.send_kind    = m_tuser[1:0];
			got.pong_value   = m_tdata[31:0];
			got.link_state   = m_tdata[33:32];
			got.retries_used = m_tdata[41:34];
			n_results++;
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing pending", '0, got);
			end else begin
				want = expected_results.pop_front();
				if (got.send_kind != want.send_kind || got.pong_value != want.pong_value ||
				    got.link_state != want.link_state ||
				    got.retries_used != want.retries_used)
					report_mismatch("result mismatch", want, got);
			end
		end
	end

	// Watchdog: count cycles with work pending and no transaction moving
	initial begin : watchdog
		int unsigned stuck;
		stuck = 0;
		while (stuck < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			    (cfg_valid && cfg_ready) ||
			    (expected_results.size() == 0 && !s_tvalid && !cfg_valid))
				stuck = 0;
			else
				stuck++;
		end
		$display("%0t: watchdog: no transaction for %0d cycles, %0d results pending",
		         $realtime, stuck, expected_results.size());
		$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Walk one session with the reset register values
	task automatic test_link_basics();
		send_event(REQ_TICK, MSG_UNDEF, 32'h0, 1'b1);          // disconnected: nothing
		send_event(REQ_CONNECT, MSG_UNDEF, 32'h0, 1'b1);
		send_event(REQ_MESSAGE, MSG_PING, 32'h0, 1'b1);        // no pong while waiting
		send_event(REQ_MESSAGE, MSG_GREETING, 32'h0, 1'b1);    // waiting -> ready
		send_event(REQ_MESSAGE, MSG_PING, 32'h0, 1'b1);        // pong with learned id zero
		send_event(REQ_MESSAGE, MSG_PONG, 32'hFFFF_FFFF, 1'b0);
		send_event(REQ_MESSAGE, MSG_PING, 32'h0, 1'b0);
		send_event(REQ_MESSAGE, MSG_GREETING, 32'h0, 1'b1);    // answered in ready
		send_event(REQ_MESSAGE, MSG_DATA, 32'h1234_5678, 1'b1);
		send_event(REQ_MESSAGE, MSG_RESERVED_HI, 32'h0, 1'b1);
		send_event(REQ_TICK, MSG_UNDEF, 32'h0, 1'b1);
		send_event(REQ_DISCONNECT, MSG_UNDEF, 32'h0, 1'b1);
		send_event(REQ_CONNECT, MSG_UNDEF, 32'h0, 1'b0);       // refused greeting -> failed
		send_event(REQ_TICK, MSG_UNDEF, 32'h0, 1'b1);
		drain();
	endtask

	// Zero limits expire on the first tick; also retry with a refused greeting
	task automatic test_zero_limits();
		apply_config(16'd0, 16'd0, 16'd0, 8'd1, 32'hFFFF_FFFF);
		send_event(REQ_CONNECT, MSG_UNDEF, 32'h0, 1'b1);
		send_event(REQ_TICK, MSG_UNDEF, 32'h0, 1'b1);          // retry
		send_event(REQ_TICK, MSG_UNDEF, 32'h0, 1'b1);          // out of retries -> failed
		send_event(REQ_CONNECT, MSG_UNDEF, 32'h0, 1'b1);
		send_event(REQ_MESSAGE, MSG_GREETING, 32'h0, 1'b1);
		send_event(REQ_MESSAGE, MSG_PING, 32'h0, 1'b1);        // pong carries own id
		send_event(REQ_TICK, MSG_UNDEF, 32'h0, 1'b0);          // silence retry, refused
		drain();
	endtask

	// Keepalive greetings while waiting, pings while ready, widest retry limit
	task automatic test_keepalive();
		apply_config(16'hFFFF, 16'd0, 16'hFFFF, 8'hFF, 32'h0);
		send_event(REQ_CONNECT, MSG_UNDEF, 32'h0, 1'b1);
		send_event(REQ_TICK, MSG_UNDEF, 32'h0, 1'b0);          // send_ok ignored here
		send_event(REQ_TICK, MSG_UNDEF, 32'h0, 1'b1);
		send_event(REQ_MESSAGE, MSG_GREETING, 32'h0, 1'b1);
		send_event(REQ_TICK, MSG_UNDEF, 32'h0, 1'b1);
		drain();
	endtask

	// Writes past the last register must leave the registers alone
	task automatic test_unmapped_index();
		cfg_write(3'd5, $urandom);
		cfg_write(3'd6, $urandom);
		cfg_write(3'd7, 32'hFFFF_FFFF);
		cfg_valid <= 1'b0;
		send_event(REQ_CONNECT, MSG_UNDEF, 32'h0, 1'b1);
		send_event(REQ_TICK, MSG_UNDEF, 32'h0, 1'b1);
		drain();
	endtask

	// Pick the next event: mostly a plausible continuation of the session
	task automatic pick_event(output logic [1:0] req, output logic [2:0] kind,
			output logic [31:0] peer, output logic ok);
		int unsigned r;
		r    = $urandom_range(0, 99);
		peer = $urandom;
		ok   = ($urandom_range(0, 9) != 0);
		kind = MSG_DATA;
		req  = REQ_TICK;
		if (r < 12) begin
			// noise: any field value at all
			req  = 2'($urandom_range(0, 3));
			kind = 3'($urandom_range(0, 7));
			ok   = 1'($urandom_range(0, 1));
		end else begin
			r = $urandom_range(0, 99);
			case (lk_mode)
				LINK_WAITING: begin
					if (r < 8) begin
						req  = REQ_MESSAGE;
						kind = MSG_GREETING;
					end else if (r < 12) begin
						req  = REQ_MESSAGE;
						kind = $urandom_range(0, 1) ? MSG_PONG : MSG_PING;
					end
				end
				LINK_READY: begin
					if (r < 7) begin
						req  = REQ_MESSAGE;
						kind = MSG_PING;
					end else if (r < 11) begin
						req  = REQ_MESSAGE;
						kind = MSG_PONG;
					end else if (r < 14) begin
						req  = REQ_MESSAGE;
						kind = MSG_GREETING;
					end else if (r < 17) begin
						req  = REQ_MESSAGE;
						kind = MSG_DATA;
					end else if (r < 19) begin
						req = REQ_CONNECT;
					end else if (r < 20) begin
						req = REQ_DISCONNECT;
					end
				end
				default: begin
					if (r < 60)
						req = REQ_CONNECT;
					else if (r < 90)
						req = REQ_TICK;
					else begin
						req  = REQ_MESSAGE;
						kind = 3'($urandom_range(0, 7));
					end
				end
			endcase
		end
	endtask

	task automatic test_random_phase(input int unsigned n_ev, input logic [15:0] ct,
			input logic [15:0] ki, input logic [15:0] dt, input logic [7:0] mr,
			input logic [31:0] oid);
		logic [1:0]  req;
		logic [2:0]  kind;
		logic [31:0] peer;
		logic        ok;
		drain();
		apply_config(ct, ki, dt, mr, oid);
		repeat (n_ev) begin
			pick_event(req, kind, peer, ok);
			send_event(req, kind, peer, ok);
		end
		drain();
	endtask

	// Hold the result side for a long stretch; the input must stall, not drop
	task automatic test_output_backpressure();
		logic [1:0]  req;
		logic [2:0]  kind;
		logic [31:0] peer;
		logic        ok;
		apply_config(16'd6, 16'd2, 16'd5, 8'd2, 32'h0);
		rx_hold_req = LONG_HOLD;
		send_event(REQ_CONNECT, MSG_UNDEF, 32'h0, 1'b1);
		send_event(REQ_MESSAGE, MSG_GREETING, 32'h0, 1'b1);
		repeat (40) begin
			pick_event(req, kind, peer, ok);
			send_event(req, kind, peer, ok);
		end
		drain();
	endtask

	initial begin : main
		lk_mode       = LINK_DISCONNECTED;
		link_clear();
		learned_peer  = '0;
		lim_connect   = 16'd1000;
		lim_keepalive = 16'd250;
		lim_silence   = 16'd2000;
		retry_limit   = 8'd3;
		local_id      = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_link_basics();
		test_zero_limits();
		test_keepalive();
		test_unmapped_index();
		test_output_backpressure();

		// Short limits so timeouts, retries and give-ups come often
		repeat (4)
			test_random_phase(80, 16'($urandom_range(0, 12)), 16'($urandom_range(0, 6)),
			                  16'($urandom_range(0, 12)), 8'($urandom_range(0, 4)),
			                  $urandom_range(0, 1) ? $urandom : 32'h0);
		test_random_phase(60, 16'd1, 16'hFFFF, 16'd1, 8'hFF, 32'hFFFF_FFFF);
		test_random_phase(60, 16'hFFFF, 16'd1, 16'hFFFF, 8'd0, 32'h0);
		// Final stretch runs at full rate on both sides
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		test_random_phase(60, 16'($urandom_range(0, 8)), 16'($urandom_range(0, 4)),
		                  16'($urandom_range(0, 8)), 8'($urandom_range(0, 3)), $urandom);

		repeat (8) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0d predicted results never arrived", expected_results.size());
			n_errors += expected_results.size();
		end
		$display("Covered %0d events, %0d results, %0d register writes",
		         n_items, n_results, n_cfg);
		$display("Retries %0d, give-ups %0d; sent %0d greeting, %0d ping, %0d pong; %0d errors",
		         n_retries, n_giveups, n_sends[SEND_GREETING], n_sends[SEND_PING],
		         n_sends[SEND_PONG], n_errors);
		if (n_errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
